// ----- design/tsq_pkg.sv -----
// ----------------------------------------------------------------------------
// tsq_pkg: shared constants and types of the two-stack queue
// Holds the stack depth, the derived pointer and count widths, the operation
// and status codes, and the one-hot state type of the controller.
// ----------------------------------------------------------------------------
package tsq_pkg;

    localparam int DEPTH  = 16;
    localparam int WORD_W = 32;
    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MOVE = 4'b0010,
        S_POP  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

endpackage

// ----- design/two_stack_queue.sv -----
// ----------------------------------------------------------------------------
// two_stack_queue: FIFO of 32-bit words built from two stacks
// Enqueue pushes onto the input stack (dropped with FULL status when that
// stack is full). Dequeue pops the output stack; when it is empty the input
// stack is first drained onto it, which restores arrival order.
// ----------------------------------------------------------------------------
//
//  channel | valid       | ready       | payload
//  --------+-------------+-------------+--------------------------
//  input   | i_in_valid  | o_in_ready  | i_opcode, i_data_in
//  output  | o_out_valid | i_out_ready | o_data_out, o_status
//
// An enqueue, a dropped enqueue and a dequeue on an empty queue go straight
//   to the done state; a dequeue from the output stack passes through the
//   pop state first, for the registered read of the output stack memory.
// A dequeue that finds the output stack empty drains the input stack at one
//   word per cycle (one read of the input stack memory each), and hands the
//   last word read straight over instead of pushing it.
// Reset clears both counts and the controller; the memories are not cleared,
//   since the counts never let an unwritten entry be read.
// A result waiting on a stalled output holds the controller in its done
//   state; the next beat is taken in the cycle that result is handed over.
//
module two_stack_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_opcode,
    input  logic signed [31:0] i_data_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_data_out,
    output logic [1:0]         o_status
);

    localparam int PTR_W  = tsq_pkg::PTR_W;
    localparam int CNT_W  = tsq_pkg::CNT_W;
    localparam int WORD_W = tsq_pkg::WORD_W;

    // Controller state and the two stack heights.
    tsq_pkg::t_state     r_state, n_state;
    logic [CNT_W-1:0]    r_in_cnt, n_in_cnt;
    logic [CNT_W-1:0]    r_out_cnt, n_out_cnt;

    // Result waiting to go to the output register.
    logic [WORD_W-1:0]   r_res_data, n_res_data;
    logic [1:0]          r_res_status, n_res_status;

    // Output register.
    logic                r_out_valid;
    logic [WORD_W-1:0]   r_data_out;
    logic [1:0]          r_status;

    // Memory ports.
    logic                in_we, in_re, out_we, out_re;
    logic [PTR_W-1:0]    in_waddr, in_raddr, out_waddr, out_raddr;
    logic [WORD_W-1:0]   in_rdata, out_rdata;

    logic [CNT_W-1:0]    in_dec, out_dec;
    logic                in_full, in_empty, out_empty;
    logic                slot_free, accept, load_out;

    // Top of stack is count - 1; the push slot is count itself.
    assign in_dec    = r_in_cnt - CNT_W'(1);
    assign out_dec   = r_out_cnt - CNT_W'(1);
    assign in_full   = (r_in_cnt == CNT_W'(tsq_pkg::DEPTH));
    assign in_empty  = (r_in_cnt == '0);
    assign out_empty = (r_out_cnt == '0);

    // The output register is free when empty or being drained this cycle.
    assign slot_free  = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == tsq_pkg::S_IDLE) ||
                        ((r_state == tsq_pkg::S_DONE) && slot_free);
    assign accept     = i_in_valid && o_in_ready;
    assign load_out   = (r_state == tsq_pkg::S_DONE) && slot_free;

    assign in_waddr  = r_in_cnt[PTR_W-1:0];
    assign in_raddr  = in_dec[PTR_W-1:0];
    assign out_waddr = r_out_cnt[PTR_W-1:0];
    assign out_raddr = out_dec[PTR_W-1:0];

    always_comb begin
        n_state      = r_state;
        n_in_cnt     = r_in_cnt;
        n_out_cnt    = r_out_cnt;
        n_res_data   = r_res_data;
        n_res_status = r_res_status;
        in_we        = 1'b0;
        in_re        = 1'b0;
        out_we       = 1'b0;
        out_re       = 1'b0;

        unique case (r_state)
            tsq_pkg::S_IDLE: begin
                // Nothing in flight; a new beat is handled below.
            end
            tsq_pkg::S_MOVE: begin
                if (in_empty) begin
                    // Last word read off the input stack is the one to pop:
                    // hand it straight over instead of pushing it first.
                    n_res_data   = in_rdata;
                    n_res_status = tsq_pkg::ST_OK;
                    n_state      = tsq_pkg::S_DONE;
                end else begin
                    // Push the word just read, then read the next one down.
                    out_we    = 1'b1;
                    n_out_cnt = r_out_cnt + CNT_W'(1);
                    in_re     = 1'b1;
                    n_in_cnt  = in_dec;
                end
            end
            tsq_pkg::S_POP: begin
                n_res_data   = out_rdata;
                n_res_status = tsq_pkg::ST_OK;
                n_state      = tsq_pkg::S_DONE;
            end
            tsq_pkg::S_DONE: begin
                if (slot_free) begin
                    n_state = tsq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tsq_pkg::S_IDLE;
            end
        endcase

        // Start of a new item: only possible in the idle or done state.
        if (accept) begin
            if (i_opcode == tsq_pkg::OP_ENQ) begin
                n_res_data = '0;
                if (in_full) begin
                    n_res_status = tsq_pkg::ST_FULL;
                end else begin
                    in_we        = 1'b1;
                    n_in_cnt     = r_in_cnt + CNT_W'(1);
                    n_res_status = tsq_pkg::ST_OK;
                end
                n_state = tsq_pkg::S_DONE;
            end else if (in_empty && out_empty) begin
                n_res_data   = '1;
                n_res_status = tsq_pkg::ST_EMPTY;
                n_state      = tsq_pkg::S_DONE;
            end else if (!out_empty) begin
                out_re    = 1'b1;
                n_out_cnt = out_dec;
                n_state   = tsq_pkg::S_POP;
            end else begin
                // Output stack empty: begin draining the input stack.
                in_re    = 1'b1;
                n_in_cnt = in_dec;
                n_state  = tsq_pkg::S_MOVE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= tsq_pkg::S_IDLE;
            r_in_cnt  <= '0;
            r_out_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_in_cnt  <= n_in_cnt;
            r_out_cnt <= n_out_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_data   <= n_res_data;
        r_res_status <= n_res_status;
    end

    // Output register: load from the done state, drop valid once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_data_out <= r_res_data;
            r_status   <= r_res_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_data_out  = r_data_out;
    assign o_status    = r_status;

    tsq_ram #(
        .DEPTH (tsq_pkg::DEPTH),
        .WIDTH (WORD_W),
        .ADDR_W(PTR_W)
    ) u_in_stack (
        .i_clk  (i_clk),
        .i_we   (in_we),
        .i_waddr(in_waddr),
        .i_wdata(i_data_in),
        .i_re   (in_re),
        .i_raddr(in_raddr),
        .o_rdata(in_rdata)
    );

    tsq_ram #(
        .DEPTH (tsq_pkg::DEPTH),
        .WIDTH (WORD_W),
        .ADDR_W(PTR_W)
    ) u_out_stack (
        .i_clk  (i_clk),
        .i_we   (out_we),
        .i_waddr(out_waddr),
        .i_wdata(in_rdata),
        .i_re   (out_re),
        .i_raddr(out_raddr),
        .o_rdata(out_rdata)
    );

endmodule

// ----- design/tsq_ram.sv -----
// ----------------------------------------------------------------------------
// tsq_ram: single-clock stack store
// One write port and one read port; read data is registered.
// Contents are undefined until written.
// ----------------------------------------------------------------------------
module tsq_ram #(
    parameter int DEPTH  = 16,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/tsq_checker.sv -----
// ----------------------------------------------------------------------------
// tsq_checker: port-level checks of the two-stack queue
// Watches the output channel handshake and the consistency of each result.
// ----------------------------------------------------------------------------
module tsq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_data_out,
    input logic [1:0]  o_status
);

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output valid dropped while stalled");

    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_data_out) && $stable(o_status))
        else $error("output beat changed while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == tsq_pkg::ST_OK || o_status == tsq_pkg::ST_EMPTY ||
                         o_status == tsq_pkg::ST_FULL))
        else $error("unknown status code");

    a_empty_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == tsq_pkg::ST_EMPTY |-> o_data_out == 32'hFFFF_FFFF)
        else $error("empty dequeue must return all ones");

    a_full_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == tsq_pkg::ST_FULL |-> o_data_out == 32'h0)
        else $error("dropped enqueue must return zero");

endmodule

bind two_stack_queue tsq_checker u_tsq_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_data_out (o_data_out),
    .o_status   (o_status)
);
